>>> hw/rtl/bw2d_pkg.sv
// shared widths and types for the barycentric weight pipeline
package bw2d_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 32;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int N0_W   = PROD_W + 2;
    localparam int QB     = OUT_W + 1;
    localparam int REM_W  = N0_W + FRAC_BITS + 1;
    localparam int CMP_W  = (REM_W > SUM_W + QB) ? REM_W : SUM_W + QB;
    localparam int STEPS  = QB + 1;
    localparam int LANES  = 3;

    typedef struct packed {
        logic [CMP_W-1:0] rem;
        logic [QB-1:0]    quo;
        logic             neg;
        logic             ovf;
    } lane_t;

endpackage

>>> hw/rtl/barycentric_weights_2d.sv
// barycentric weights of a point in a 2d triangle, fully pipelined
// One transaction is taken in every cycle (busy stays low) and its result
// shows on done after it passes, in order, through one stage of edge
// differences, one of multipliers, one of cross-product sums, one that
// forms magnitudes, 34 restoring divide steps (an overflow test and 33
// quotient bits, one per stage for all three weights), and the rounding
// and saturation stage. The receiver cannot stall, so nothing waits.
module barycentric_weights_2d
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] vert0_x,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] vert0_y,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] vert1_x,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] vert1_y,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] vert2_x,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] vert2_y,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [bw2d_pkg::COORD_BITS-1:0] point_y,
    output logic                                 done,
    output logic signed [bw2d_pkg::OUT_W-1:0]    weight0,
    output logic signed [bw2d_pkg::OUT_W-1:0]    weight1,
    output logic signed [bw2d_pkg::OUT_W-1:0]    weight2,
    output logic                                 degenerate
);

    localparam int DW = bw2d_pkg::DIFF_W;
    localparam int PW = bw2d_pkg::PROD_W;
    localparam int SW = bw2d_pkg::SUM_W;
    localparam int NW = bw2d_pkg::N0_W;
    localparam int CW = bw2d_pkg::CMP_W;
    localparam int QB = bw2d_pkg::QB;
    localparam int OW = bw2d_pkg::OUT_W;
    localparam int ST = bw2d_pkg::STEPS;
    localparam int LN = bw2d_pkg::LANES;
    localparam int FB = bw2d_pkg::FRAC_BITS;

    logic signed [DW-1:0] diff_reg [6];
    logic signed [DW-1:0] diff_next [6];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] prod_next [6];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [SW-1:0] sum_next [3];
    logic                 d_vld_reg, p_vld_reg, s_vld_reg;

    bw2d_pkg::lane_t      lane_reg  [ST+1][LN];
    bw2d_pkg::lane_t      lane_next [ST+1][LN];
    logic [SW-1:0]        md_reg  [ST+1];
    logic                 deg_reg [ST+1];
    logic                 vld_reg [ST+1];
    logic                 deg_next;
    logic [SW-1:0]        md_next;

    logic signed [OW-1:0] w_reg  [LN];
    logic signed [OW-1:0] w_next [LN];
    logic                 deg_out_reg;
    logic                 done_reg;

    assign busy = 1'b0;

    // edge and point differences
    always_comb
    begin
        diff_next[0] = DW'(vert1_x) - DW'(vert0_x);
        diff_next[1] = DW'(vert1_y) - DW'(vert0_y);
        diff_next[2] = DW'(vert2_x) - DW'(vert0_x);
        diff_next[3] = DW'(vert2_y) - DW'(vert0_y);
        diff_next[4] = DW'(point_x) - DW'(vert0_x);
        diff_next[5] = DW'(point_y) - DW'(vert0_y);
    end

    // products: u.x*v.y, v.x*u.y, q.x*v.y, q.y*v.x, q.y*u.x, q.x*u.y
    always_comb
    begin
        prod_next[0] = PW'(diff_reg[0]) * PW'(diff_reg[3]);
        prod_next[1] = PW'(diff_reg[2]) * PW'(diff_reg[1]);
        prod_next[2] = PW'(diff_reg[4]) * PW'(diff_reg[3]);
        prod_next[3] = PW'(diff_reg[5]) * PW'(diff_reg[2]);
        prod_next[4] = PW'(diff_reg[5]) * PW'(diff_reg[0]);
        prod_next[5] = PW'(diff_reg[4]) * PW'(diff_reg[1]);
    end

    always_comb
    begin
        sum_next[0] = SW'(prod_reg[0]) - SW'(prod_reg[1]);
        sum_next[1] = SW'(prod_reg[2]) - SW'(prod_reg[3]);
        sum_next[2] = SW'(prod_reg[4]) - SW'(prod_reg[5]);
    end

    // magnitudes and signs, then the divide steps
    always_comb
    begin
        logic signed [NW-1:0] num [LN];
        logic [NW-1:0]        mag;
        logic [CW-1:0]        dsh;
        logic                 ge;
        num[1] = NW'(sum_reg[1]);
        num[2] = NW'(sum_reg[2]);
        num[0] = NW'(sum_reg[0]) - num[1] - num[2];
        md_next  = sum_reg[0][SW-1] ? SW'(-sum_reg[0]) : SW'(sum_reg[0]);
        deg_next = (sum_reg[0] == '0);
        for (int l = 0; l < LN; l++)
        begin
            mag = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
            lane_next[0][l].rem = CW'(mag) << (FB + 1);
            lane_next[0][l].quo = '0;
            lane_next[0][l].neg = num[l][NW-1] ^ sum_reg[0][SW-1];
            lane_next[0][l].ovf = 1'b0;
        end
        for (int s = 0; s < ST; s++)
        begin
            for (int l = 0; l < LN; l++)
            begin
                dsh = CW'(md_reg[s]) << (QB - s);
                ge  = (lane_reg[s][l].rem >= dsh);
                lane_next[s+1][l] = lane_reg[s][l];
                if (s == 0)
                begin
                    lane_next[s+1][l].ovf = ge;
                end
                else
                begin
                    lane_next[s+1][l].quo = {lane_reg[s][l].quo[QB-2:0], ge};
                    if (ge)
                    begin
                        lane_next[s+1][l].rem = lane_reg[s][l].rem - dsh;
                    end
                end
            end
        end
    end

    // rounding to nearest and saturation
    always_comb
    begin
        logic [QB:0]   rnd;
        logic [QB-1:0] mr;
        for (int l = 0; l < LN; l++)
        begin
            rnd = (QB+1)'(lane_reg[ST][l].quo) + (QB+1)'(1);
            mr  = rnd[QB:1];
            if (deg_reg[ST])
            begin
                w_next[l] = '0;
            end
            else if (lane_reg[ST][l].neg)
            begin
                if (lane_reg[ST][l].ovf || mr >= QB'({1'b1, {(OW-1){1'b0}}}))
                    w_next[l] = {1'b1, {(OW-1){1'b0}}};
                else
                    w_next[l] = -$signed(mr[OW-1:0]);
            end
            else
            begin
                if (lane_reg[ST][l].ovf || mr > QB'({1'b0, {(OW-1){1'b1}}}))
                    w_next[l] = {1'b0, {(OW-1){1'b1}}};
                else
                    w_next[l] = $signed(mr[OW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            for (int s = 0; s <= ST; s++)
                vld_reg[s] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg  <= start;
            p_vld_reg  <= d_vld_reg;
            s_vld_reg  <= p_vld_reg;
            vld_reg[0] <= s_vld_reg;
            for (int s = 0; s < ST; s++)
                vld_reg[s+1] <= vld_reg[s];
            done_reg <= vld_reg[ST];
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        md_reg[0]  <= md_next;
        deg_reg[0] <= deg_next;
        for (int s = 0; s < ST; s++)
        begin
            md_reg[s+1]  <= md_reg[s];
            deg_reg[s+1] <= deg_reg[s];
        end
        lane_reg    <= lane_next;
        w_reg       <= w_next;
        deg_out_reg <= deg_reg[ST];
    end

    assign done       = done_reg;
    assign weight0    = w_reg[0];
    assign weight1    = w_reg[1];
    assign weight2    = w_reg[2];
    assign degenerate = deg_out_reg;

endmodule
